// ===== hdl/utf8_text_position_counter_unit_defines.svh =====
// Assertion macros for the counter unit.
`ifndef UTF8_TEXT_POSITION_COUNTER_UNIT_DEFINES_SVH
`define UTF8_TEXT_POSITION_COUNTER_UNIT_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define UTP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the next cycle.
`define UTP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/utp_pkg.sv =====
package utp_pkg;

   // Byte classes
   localparam logic [7:0] BYTE_NEWLINE   = 8'h0a;
   localparam logic [7:0] LEAD_TWO_MIN   = 8'hc2;
   localparam logic [7:0] LEAD_THREE_MIN = 8'he0;
   localparam logic [7:0] LEAD_FOUR_MIN  = 8'hf0;
   localparam logic [7:0] LEAD_LIMIT     = 8'hf5;
   localparam logic [7:0] CONT_MASK      = 8'hc0;
   localparam logic [7:0] CONT_TAG       = 8'h80;

   // Open sequence lengths
   localparam logic [2:0] SEQ_NONE  = 3'd0;
   localparam logic [2:0] SEQ_TWO   = 3'd2;
   localparam logic [2:0] SEQ_THREE = 3'd3;
   localparam logic [2:0] SEQ_FOUR  = 3'd4;

   // Column encodings
   localparam logic MODE_BYTES = 1'b0;
   localparam logic MODE_UTF16 = 1'b1;

   // Effect of one word on the counters and the open sequence
   typedef struct packed {
      logic       line_inc;
      logic       col_clear;
      logic [2:0] col_add;
      logic [2:0] pend_len;
      logic [1:0] pend_seen;
   } step_type;

endpackage

// ===== hdl/utf8_text_position_counter_unit.sv =====
// Text position counter: takes a document one byte word per cycle, while req_stall is
// low, and at the word flagged last_byte returns the zero-based line and the column
// at that offset, the column counted in UTF-8 bytes (csr_encoding_mode 0) or UTF-16
// code units (1, the reset value). A word with no_byte set carries no byte; with
// last_byte also set it only returns the current position. A new word is taken every
// cycle while req_stall is low. Each word is first held in the input register; its
// result is then loaded into the result register and held there until rsp_stall is
// low. The line and column counters take each byte's effect from the input register
// when the pipe moves, so a new word can enter while the last one is being counted.
// While a result waits under rsp_stall the whole pipe holds and req_stall is high.
// Both counters saturate at 2^COUNT_WIDTH - 1, and the outputs at 32 bits of ones.
// Change the encoding only while no word is in flight.
`include "utf8_text_position_counter_unit_defines.svh"

module utf8_text_position_counter_unit #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // input words
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   input  logic        req_no_byte,
   input  logic        req_last_byte,
   // results
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_line_number,
   output logic [31:0] rsp_column_units,
   // encoding register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_encoding_mode
);
   import utp_pkg::*;

   // Saturating add of a small step to a counter.
   function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] c,
                                                       input logic [2:0] n);
      logic [COUNT_WIDTH:0] s;
      s = {1'b0, c} + {{(COUNT_WIDTH - 2){1'b0}}, n};
      return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
   endfunction

   // Clamp a counter to the 32-bit output range.
   function automatic logic [31:0] clamp_out(input logic [COUNT_WIDTH-1:0] c);
      logic [63:0] e;
      e = 64'(c);
      return (e > 64'h0000_0000_ffff_ffff) ? 32'hffff_ffff : e[31:0];
   endfunction

   logic                   advance;

   // input register
   logic                   s1_valid_ff, s1_valid_in;
   logic [7:0]             s1_byte_ff;
   logic                   s1_none_ff;
   logic                   s1_last_ff;

   // counting state
   logic                   encoding_mode_ff, encoding_mode_in;
   logic [COUNT_WIDTH-1:0] line_count_ff, line_count_in;
   logic [COUNT_WIDTH-1:0] column_count_ff, column_count_in;
   logic [2:0]             pend_len_ff, pend_len_in;
   logic [1:0]             pend_seen_ff, pend_seen_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [31:0]            line_out_ff, line_out_in;
   logic [31:0]            column_out_ff, column_out_in;

   step_type               step;
   logic [COUNT_WIDTH-1:0] line_next;
   logic [COUNT_WIDTH-1:0] column_next;
   logic                   take;
   logic                   emit;

   // The pipe moves whenever the result register is free or being emptied.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   assign take = advance && s1_valid_ff;
   assign emit = take && s1_last_ff;

   utp_byte_decode u_decode (
      .text_byte     (s1_byte_ff),
      .no_byte       (s1_none_ff),
      .last_byte     (s1_last_ff),
      .encoding_mode (encoding_mode_ff),
      .pend_len      (pend_len_ff),
      .pend_seen     (pend_seen_ff),
      .step          (step)
   );

   always_comb begin
      // position after this word, before the reset that follows an emission
      line_next   = step.line_inc ? sat_add(line_count_ff, 3'd1) : line_count_ff;
      column_next = step.col_clear ? {COUNT_WIDTH{1'b0}}
                                   : sat_add(column_count_ff, step.col_add);

      encoding_mode_in = (csr_valid && csr_ready) ? csr_encoding_mode : encoding_mode_ff;

      s1_valid_in = advance ? req_valid : s1_valid_ff;

      line_count_in   = line_count_ff;
      column_count_in = column_count_ff;
      pend_len_in     = pend_len_ff;
      pend_seen_in    = pend_seen_ff;
      if (take) begin
         // restart the counters once the position has been taken out
         line_count_in   = s1_last_ff ? {COUNT_WIDTH{1'b0}} : line_next;
         column_count_in = s1_last_ff ? {COUNT_WIDTH{1'b0}} : column_next;
         pend_len_in     = step.pend_len;
         pend_seen_in    = step.pend_seen;
      end

      rsp_valid_in  = advance ? emit : rsp_valid_ff;
      line_out_in   = emit ? clamp_out(line_next) : line_out_ff;
      column_out_in = emit ? clamp_out(column_next) : column_out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         encoding_mode_ff <= MODE_UTF16;
         line_count_ff    <= '0;
         column_count_ff  <= '0;
         pend_len_ff      <= SEQ_NONE;
         pend_seen_ff     <= 2'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         s1_valid_ff      <= s1_valid_in;
         encoding_mode_ff <= encoding_mode_in;
         line_count_ff    <= line_count_in;
         column_count_ff  <= column_count_in;
         pend_len_ff      <= pend_len_in;
         pend_seen_ff     <= pend_seen_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Payload registers: load only when the pipe moves.
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_byte_ff <= req_text_byte;
         s1_none_ff <= req_no_byte;
         s1_last_ff <= req_last_byte;
      end
      line_out_ff   <= line_out_in;
      column_out_ff <= column_out_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_line_number  = line_out_ff;
   assign rsp_column_units = column_out_ff;

   // A final word always leaves a result behind it.
   `UTP_ASSERT_NEXT(a_emit_result, emit, rsp_valid_ff, "final word left no result")
   // After a result the counters and the open sequence start again from zero.
   `UTP_ASSERT_NEXT(a_emit_restart, emit,
      (line_count_ff == '0) && (column_count_ff == '0) && (pend_len_ff == SEQ_NONE),
      "counters not restarted after result")
   // Byte mode never opens a sequence.
   `UTP_ASSERT_NEXT(a_bytes_no_open,
      take && (encoding_mode_ff == MODE_BYTES) && (pend_len_ff == SEQ_NONE),
      pend_len_ff == SEQ_NONE, "sequence opened in byte mode")
   // An open sequence has always taken fewer continuations than it needs.
   `UTP_ASSERT_SAME(a_seen_bound, pend_len_ff != SEQ_NONE,
      ({1'b0, pend_seen_ff} + 3'd1) < pend_len_ff, "open sequence overfilled")

endmodule

// ===== hdl/utp_byte_decode.sv =====
module utp_byte_decode (
   input  logic [7:0]      text_byte,
   input  logic            no_byte,
   input  logic            last_byte,
   input  logic            encoding_mode,
   input  logic [2:0]      pend_len,
   input  logic [1:0]      pend_seen,
   output utp_pkg::step_type step
);
   import utp_pkg::*;

   logic [2:0] seen_inc;
   logic [2:0] flush_amt;
   logic [2:0] byte_add;
   logic [2:0] len_b;
   logic [1:0] seen_b;
   logic       line_inc;
   logic       col_clear;

   always_comb begin
      seen_inc  = {1'b0, pend_seen} + 3'd1;
      flush_amt = 3'd0;
      byte_add  = 3'd0;
      len_b     = pend_len;
      seen_b    = pend_seen;
      line_inc  = 1'b0;
      col_clear = 1'b0;
      if (!no_byte) begin
         if ((pend_len != SEQ_NONE) && (encoding_mode == MODE_UTF16) &&
             ((text_byte & CONT_MASK) == CONT_TAG)) begin
            // continuation: complete the sequence or take one more byte
            if ((seen_inc + 3'd1) >= pend_len) begin
               byte_add = (pend_len == SEQ_FOUR) ? 3'd2 : 3'd1;
               len_b    = SEQ_NONE;
               seen_b   = 2'd0;
            end else begin
               seen_b = seen_inc[1:0];
            end
         end else begin
            // close a broken sequence, then treat the byte as fresh
            flush_amt = (pend_len != SEQ_NONE) ? seen_inc : 3'd0;
            len_b     = SEQ_NONE;
            seen_b    = 2'd0;
            if (text_byte == BYTE_NEWLINE) begin
               line_inc  = 1'b1;
               col_clear = 1'b1;
            end else if ((encoding_mode == MODE_BYTES) || (text_byte < LEAD_TWO_MIN) ||
                         (text_byte >= LEAD_LIMIT)) begin
               byte_add = flush_amt + 3'd1;
            end else begin
               byte_add = flush_amt;
               if (text_byte < LEAD_THREE_MIN) begin
                  len_b = SEQ_TWO;
               end else if (text_byte < LEAD_FOUR_MIN) begin
                  len_b = SEQ_THREE;
               end else begin
                  len_b = SEQ_FOUR;
               end
            end
         end
      end

      step.line_inc  = line_inc;
      step.col_clear = col_clear;
      step.col_add   = byte_add;
      step.pend_len  = len_b;
      step.pend_seen = seen_b;
      if (last_byte) begin
         // drop a sequence cut off by the offset, one unit per byte taken
         if (len_b != SEQ_NONE) begin
            step.col_add = byte_add + {1'b0, seen_b} + 3'd1;
         end
         step.pend_len  = SEQ_NONE;
         step.pend_seen = 2'd0;
      end
   end

endmodule
